// ===== rtl/core/cbez_pkg.sv =====
`timescale 1ns / 1ps
// Package for the cubic Bezier point generator: widths, sequencer step codes
// and the reciprocal table for the parameter increment. No dependencies.

package cbez_pkg;

  localparam int MAX_POINTS  = 64;
  localparam int COORD_WIDTH = 16;
  localparam int T_FRAC_BITS = 16;

  localparam int CNT_W     = $clog2(MAX_POINTS) + 1;
  localparam int IDX_W     = $clog2(MAX_POINTS);
  localparam int T_W       = T_FRAC_BITS + 1;
  localparam int SQ_W      = 2 * T_FRAC_BITS + 1;
  localparam int W_W       = 3 * T_FRAC_BITS + 1;
  localparam int B_W       = (T_W + 1 > COORD_WIDTH) ? T_W + 1 : COORD_WIDTH;
  localparam int PROD_W    = W_W + 1 + B_W;
  localparam int SUM_SHIFT = 3 * T_FRAC_BITS;

  localparam int IN_DATA_W  = ((8 * COORD_WIDTH + CNT_W + 7) / 8) * 8;
  localparam int OUT_BITS   = 2 * COORD_WIDTH + IDX_W;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [T_W-1:0] T_ONE = {1'b1, {T_FRAC_BITS{1'b0}}};

  // sequencer steps: S_UU to S_W3Y each issue one product, S_TT to S_TAIL each retire the previous one
  localparam logic [3:0] S_UU  = 4'd0;
  localparam logic [3:0] S_TT  = 4'd1;
  localparam logic [3:0] S_UUU = 4'd2;
  localparam logic [3:0] S_UUT = 4'd3;
  localparam logic [3:0] S_UTT = 4'd4;
  localparam logic [3:0] S_TTT = 4'd5;
  localparam logic [3:0] S_W0X = 4'd6;
  localparam logic [3:0] S_W0Y = 4'd7;
  localparam logic [3:0] S_W1X = 4'd8;
  localparam logic [3:0] S_W1Y = 4'd9;
  localparam logic [3:0] S_W2X = 4'd10;
  localparam logic [3:0] S_W2Y = 4'd11;
  localparam logic [3:0] S_W3X = 4'd12;
  localparam logic [3:0] S_W3Y = 4'd13;
  localparam logic [3:0] S_TAIL = 4'd14;
  localparam logic [3:0] S_OUT = 4'd15;

  // floor(2^T_FRAC_BITS / n), indexed by n - 1
  function automatic logic [T_W-1:0] inc_lookup(input logic [IDX_W-1:0] nm1);
    logic [T_W-1:0] v;
    case (nm1)
      6'd0:  v = 17'd65536;  6'd1:  v = 17'd32768;  6'd2:  v = 17'd21845;
      6'd3:  v = 17'd16384;  6'd4:  v = 17'd13107;  6'd5:  v = 17'd10922;
      6'd6:  v = 17'd9362;   6'd7:  v = 17'd8192;   6'd8:  v = 17'd7281;
      6'd9:  v = 17'd6553;   6'd10: v = 17'd5957;   6'd11: v = 17'd5461;
      6'd12: v = 17'd5041;   6'd13: v = 17'd4681;   6'd14: v = 17'd4369;
      6'd15: v = 17'd4096;   6'd16: v = 17'd3855;   6'd17: v = 17'd3640;
      6'd18: v = 17'd3449;   6'd19: v = 17'd3276;   6'd20: v = 17'd3120;
      6'd21: v = 17'd2978;   6'd22: v = 17'd2849;   6'd23: v = 17'd2730;
      6'd24: v = 17'd2621;   6'd25: v = 17'd2520;   6'd26: v = 17'd2427;
      6'd27: v = 17'd2340;   6'd28: v = 17'd2259;   6'd29: v = 17'd2184;
      6'd30: v = 17'd2114;   6'd31: v = 17'd2048;   6'd32: v = 17'd1985;
      6'd33: v = 17'd1927;   6'd34: v = 17'd1872;   6'd35: v = 17'd1820;
      6'd36: v = 17'd1771;   6'd37: v = 17'd1724;   6'd38: v = 17'd1680;
      6'd39: v = 17'd1638;   6'd40: v = 17'd1598;   6'd41: v = 17'd1560;
      6'd42: v = 17'd1524;   6'd43: v = 17'd1489;   6'd44: v = 17'd1456;
      6'd45: v = 17'd1424;   6'd46: v = 17'd1394;   6'd47: v = 17'd1365;
      6'd48: v = 17'd1337;   6'd49: v = 17'd1310;   6'd50: v = 17'd1285;
      6'd51: v = 17'd1260;   6'd52: v = 17'd1236;   6'd53: v = 17'd1213;
      6'd54: v = 17'd1191;   6'd55: v = 17'd1170;   6'd56: v = 17'd1149;
      6'd57: v = 17'd1129;   6'd58: v = 17'd1110;   6'd59: v = 17'd1092;
      6'd60: v = 17'd1074;   6'd61: v = 17'd1057;   6'd62: v = 17'd1040;
      6'd63: v = 17'd1024;
      default: v = 17'd1024;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/core/cubic_bezier_point_generator.sv =====
`timescale 1ns / 1ps
// Cubic Bezier point generator top level: one shared 50x18 multiplier under
// a 16-step sequencer per point. Depends on cbez_pkg.
// Each point takes 14 products on the shared multiplier plus a retire step and
// an output step; the output step waits while the output register is stalled.
// in_tready is low during the request, so the next request is taken only after
// the last point of this one has been handed to the output register.
// Reset (rst_n low, synchronous) clears sequencer and output valid only.

module cubic_bezier_point_generator
  import cbez_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // start_x, start_y, ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y, end_x, end_y,
  // point_count, zero pad
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // curve_x, curve_y, point_index, zero pad
  output logic [OUT_DATA_W-1:0] out_tdata,
  // last_point
  output logic                  out_tlast
);

  logic                    busy_r;
  logic [3:0]              step_r;
  logic [CNT_W-1:0]        cnt_r;
  logic [CNT_W-1:0]        idx_r;
  logic [T_W-1:0]          inc_r;
  logic [T_W-1:0]          t_r;
  logic [COORD_WIDTH-1:0]  held_r [8];
  logic [SQ_W-1:0]         u2_r;
  logic [SQ_W-1:0]         t2_r;
  logic [W_W-1:0]          w_r [4];
  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W-1:0] acc_x_r;
  logic signed [PROD_W-1:0] acc_y_r;

  logic                    out_valid_r;
  logic [COORD_WIDTH-1:0]  out_x_r;
  logic [COORD_WIDTH-1:0]  out_y_r;
  logic [IDX_W-1:0]        out_idx_r;
  logic                    out_last_r;

  logic                    in_acc;
  logic [CNT_W-1:0]        n_sat;
  logic [T_W-1:0]          u_val;
  logic [W_W-1:0]          mul_a;
  logic signed [B_W-1:0]   mul_b;
  logic signed [W_W:0]     mul_as;
  logic [2:0]              coord_sel;
  logic [COORD_WIDTH-1:0]  coord;
  logic [W_W-1:0]          prod_lo;
  logic [W_W-1:0]          prod_x3;
  logic                    out_free;
  logic                    pt_last;

  localparam logic [PROD_W-1:0] RND_INIT =
    {{(PROD_W - SUM_SHIFT){1'b0}}, 1'b1, {(SUM_SHIFT - 1){1'b0}}};

  assign in_tready = !busy_r;
  assign in_acc    = in_tvalid && in_tready;
  assign n_sat     = (in_tdata[8*COORD_WIDTH +: CNT_W] > CNT_W'(MAX_POINTS)) ?
                     CNT_W'(MAX_POINTS) : in_tdata[8*COORD_WIDTH +: CNT_W];

  assign u_val     = T_ONE - t_r;
  assign coord_sel = 3'(step_r - S_W0X);
  assign coord     = held_r[coord_sel];
  assign prod_lo   = prod_r[W_W-1:0];
  assign prod_x3   = prod_lo + {prod_lo[W_W-2:0], 1'b0};
  assign out_free  = !out_valid_r || out_tready;
  assign pt_last   = (idx_r + 1'b1) == cnt_r;

  always_comb begin
    mul_a = {{(W_W - T_W){1'b0}}, u_val};
    mul_b = {{(B_W - T_W){1'b0}}, u_val};
    case (step_r)
      S_UU: begin
        mul_a = {{(W_W - T_W){1'b0}}, u_val};
        mul_b = {{(B_W - T_W){1'b0}}, u_val};
      end
      S_TT: begin
        mul_a = {{(W_W - T_W){1'b0}}, t_r};
        mul_b = {{(B_W - T_W){1'b0}}, t_r};
      end
      S_UUU: begin
        mul_a = {{(W_W - SQ_W){1'b0}}, u2_r};
        mul_b = {{(B_W - T_W){1'b0}}, u_val};
      end
      S_UUT: begin
        mul_a = {{(W_W - SQ_W){1'b0}}, u2_r};
        mul_b = {{(B_W - T_W){1'b0}}, t_r};
      end
      S_UTT: begin
        mul_a = {{(W_W - SQ_W){1'b0}}, t2_r};
        mul_b = {{(B_W - T_W){1'b0}}, u_val};
      end
      S_TTT: begin
        mul_a = {{(W_W - SQ_W){1'b0}}, t2_r};
        mul_b = {{(B_W - T_W){1'b0}}, t_r};
      end
      S_W0X, S_W0Y, S_W1X, S_W1Y, S_W2X, S_W2Y, S_W3X, S_W3Y: begin
        mul_a = w_r[coord_sel[2:1]];
        mul_b = {{(B_W - COORD_WIDTH){coord[COORD_WIDTH-1]}}, coord};
      end
      default: begin
        mul_a = {{(W_W - T_W){1'b0}}, u_val};
        mul_b = {{(B_W - T_W){1'b0}}, u_val};
      end
    endcase
  end

  assign mul_as = {1'b0, mul_a};

  // shared multiplier, registered
  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(mul_as * mul_b);
  end

  // retire the product issued in the previous step (S_UU presets the accumulators)
  always_ff @(posedge clk) begin
    case (step_r)
      S_UU: begin
        acc_x_r <= RND_INIT;
        acc_y_r <= RND_INIT;
      end
      S_TT:   u2_r <= prod_r[SQ_W-1:0];
      S_UUU:  t2_r <= prod_r[SQ_W-1:0];
      S_UUT:  w_r[0] <= prod_lo;
      S_UTT:  w_r[1] <= prod_x3;
      S_TTT:  w_r[2] <= prod_x3;
      S_W0X:  w_r[3] <= prod_lo;
      S_W0Y, S_W1Y, S_W2Y, S_W3Y: acc_x_r <= acc_x_r + prod_r;
      S_W1X, S_W2X, S_W3X, S_TAIL: acc_y_r <= acc_y_r + prod_r;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      for (int k = 0; k < 8; k++) begin
        held_r[k] <= in_tdata[k*COORD_WIDTH +: COORD_WIDTH];
      end
      inc_r <= inc_lookup(IDX_W'(n_sat - 1'b1));
      cnt_r <= n_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= S_UU;
      idx_r  <= '0;
      t_r    <= '0;
    end else if (in_acc) begin
      busy_r <= (n_sat != '0);
      step_r <= S_UU;
      idx_r  <= '0;
      t_r    <= '0;
    end else if (busy_r) begin
      if (step_r == S_OUT) begin
        if (out_free) begin
          step_r <= S_UU;
          idx_r  <= idx_r + 1'b1;
          t_r    <= t_r + inc_r;
          if (pt_last) begin
            busy_r <= 1'b0;
          end
        end
      end else begin
        step_r <= step_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (busy_r && step_r == S_OUT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r && step_r == S_OUT && out_free) begin
      out_x_r    <= acc_x_r[SUM_SHIFT +: COORD_WIDTH];
      out_y_r    <= acc_y_r[SUM_SHIFT +: COORD_WIDTH];
      out_idx_r  <= idx_r[IDX_W-1:0];
      out_last_r <= pt_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {{(OUT_DATA_W - OUT_BITS){1'b0}}, out_idx_r, out_y_r, out_x_r};

  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tdata[8*COORD_WIDTH +: CNT_W] != '0) |=> busy_r && step_r == S_UU)
    else $error("request with points did not start the sequencer");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> idx_r < cnt_r)
    else $error("point index beyond point count");

  a_idle_step: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> step_r == S_UU)
    else $error("sequencer not parked while idle");

  a_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && step_r == S_OUT && out_free) |=> out_tvalid)
    else $error("finished point not offered");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && step_r == S_OUT && out_free && pt_last) |=> !busy_r)
    else $error("request did not end after its last point");

endmodule
